// ----- rtl/core/bfac_pkg.sv -----
package bfac_pkg;

  localparam int unsigned FilterBitsDef  = 65536;
  localparam int unsigned MaxKeyBytesDef = 8;
  localparam int unsigned MaxProbes      = 32;

  localparam logic [31:0] HashSeed = 32'h9747b28c;
  localparam logic [31:0] MixMul   = 32'h5bd1e995;

  localparam logic [1:0] ActCheck = 2'd0;
  localparam logic [1:0] ActAdd   = 2'd1;
  localparam logic [1:0] ActClear = 2'd2;

  localparam logic [1:0] RegEnable = 2'd0;
  localparam logic [1:0] RegHashCount = 2'd1;
  localparam logic [1:0] RegBitCount = 2'd2;

  localparam logic [5:0]  HashCountRst = 6'd7;
  localparam logic [16:0] BitCountRst  = 17'd65536;

endpackage

// ----- rtl/core/bloom_filter_add_check_top.sv -----
// Bloom filter add and check over a single-port bit store of FILTER_BITS
// bits held in a synchronous memory with a registered read. Each request
// hashes its key with two MurmurHash2 passes, computed one 4-byte block at
// a time and one multiply per cycle on a shared 32x32 multiplier, then
// probes hash_count positions, at most 32. Each probe takes a start step, a
// 32-bit by 17-bit modulo done bit-serially, then the address, the read and
// the test with, for add, a write back of the bit; a check stops at the
// first clear bit. A clear request, and the clearing pass after reset,
// sweep the memory one entry a cycle; no request is taken during the sweep.
// When the filter is not enabled, or the action is unused, a request goes
// straight to its result without hashing, status set when not enabled. One
// request is in work at a time; a finished result waits in an output
// register until it is taken, and the next request is taken and worked on
// meanwhile.
module bloom_filter_add_check_top
  import bfac_pkg::*;
#(
  parameter int unsigned FILTER_BITS   = FilterBitsDef,
  parameter int unsigned MAX_KEY_BYTES = MaxKeyBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] key_data_i,
  input  logic [3:0]  key_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        present_o,
  output logic        status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(FILTER_BITS);
  localparam int unsigned MW = AW + 1;
  localparam logic [MW-1:0] FilterBitsC = MW'(FILTER_BITS);
  localparam logic [3:0] MaxKeyC = 4'(MAX_KEY_BYTES);

  typedef enum logic [3:0] {
    SWipe, SIdle, SHashInit, SBlkMulK1, SBlkMulK2, SBlkMulH, STail, SFin1, SFin2,
    SNext, SMod, SRead, SWait, STest, SDone
  } state_e;

  state_e state_q;
  logic        mem_q [FILTER_BITS];
  logic        rd_q;
  logic [AW-1:0] addr_q;
  logic        en_q;
  logic [5:0]  hcnt_q;
  logic [16:0] bcnt_q;
  logic [1:0]  act_q;
  logic [63:0] key_q;
  logic [3:0]  len_q;
  logic [3:0]  pos_q;
  logic        pass_q;
  logic [31:0] h_q, k_q, a_q, b_q, x_q;
  logic [5:0]  n_q, i_q;
  logic [MW-1:0] m_q;
  logic [MW-1:0] rem_q;
  logic [5:0]  bit_q;
  logic        all_q;
  logic        stat_q;
  logic        present_q, status_q, ovalid_q;

  logic [31:0] mul_a, mul_y;
  logic [31:0] blk;
  logic [MW:0] rem_sh;
  logic        wr_en;
  logic        wr_val;
  logic        out_free;

  assign mul_y = mul_a * MixMul;
  assign blk = key_q[pos_q*8 +: 32];
  assign rem_sh = {rem_q, x_q[31 - bit_q[4:0]]};
  assign out_free = !ovalid_q || !out_stall_i;

  always_comb begin
    case (state_q)
      SBlkMulK1, SBlkMulK2: mul_a = k_q;
      default: mul_a = h_q;
    endcase
  end

  assign wr_en  = (state_q == SWipe) || (state_q == STest && act_q == ActAdd);
  assign wr_val = (state_q != SWipe);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr_q] <= wr_val;
    end
    rd_q <= mem_q[addr_q];
  end

  assign in_stall_o  = (state_q != SIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovalid_q;
  assign present_o   = present_q;
  assign status_o    = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SWipe;
      addr_q <= '0;
      en_q <= 1'b0;
      hcnt_q <= HashCountRst;
      bcnt_q <= BitCountRst;
      ovalid_q <= 1'b0;
      present_q <= 1'b0;
      status_q <= 1'b0;
      act_q <= '0; key_q <= '0; len_q <= '0; pos_q <= '0; pass_q <= 1'b0;
      h_q <= '0; k_q <= '0; a_q <= '0; b_q <= '0; x_q <= '0;
      n_q <= '0; i_q <= '0; m_q <= '0; rem_q <= '0; bit_q <= '0; all_q <= 1'b0;
      stat_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegEnable:    en_q <= cfg_data_i[0];
          RegHashCount: hcnt_q <= cfg_data_i[5:0];
          RegBitCount:  bcnt_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (state_q == SDone && out_free) begin
        ovalid_q <= 1'b1;
      end else if (ovalid_q && !out_stall_i) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        SWipe: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == AW'(FILTER_BITS - 1)) begin
            if (act_q == ActClear) begin
              all_q <= 1'b0;
              stat_q <= 1'b0;
              act_q <= ActCheck;
              state_q <= SDone;
            end else begin
              state_q <= SIdle;
            end
          end
        end
        SIdle: begin
          if (in_valid_i && !in_stall_o) begin
            act_q <= action_i;
            key_q <= key_data_i;
            len_q <= (key_length_i > MaxKeyC) ? MaxKeyC : key_length_i;
            pass_q <= 1'b0;
            n_q <= (hcnt_q > 6'(MaxProbes)) ? 6'(MaxProbes) : hcnt_q;
            if (bcnt_q == '0) m_q <= MW'(1);
            else if ({15'd0, bcnt_q} > 32'(FilterBitsC)) m_q <= FilterBitsC;
            else m_q <= MW'(bcnt_q);
            if (!en_q) begin
              all_q <= 1'b0;
              stat_q <= 1'b1;
              state_q <= SDone;
            end else if (action_i == ActClear) begin
              addr_q <= '0;
              state_q <= SWipe;
            end else if (action_i == ActAdd || action_i == ActCheck) begin
              state_q <= SHashInit;
            end else begin
              all_q <= 1'b0;
              stat_q <= 1'b0;
              state_q <= SDone;
            end
          end
        end
        SHashInit: begin
          h_q <= (pass_q ? a_q : HashSeed) ^ {28'd0, len_q};
          pos_q <= '0;
          if (len_q >= 4'd4) begin
            k_q <= key_q[31:0];
            state_q <= SBlkMulK1;
          end else begin
            state_q <= STail;
          end
        end
        SBlkMulK1: begin
          k_q <= mul_y ^ (mul_y >> 24);
          state_q <= SBlkMulK2;
        end
        SBlkMulK2: begin
          k_q <= mul_y;
          state_q <= SBlkMulH;
        end
        SBlkMulH: begin
          h_q <= mul_y ^ k_q;
          pos_q <= pos_q + 4'd4;
          if (len_q - pos_q - 4'd4 >= 4'd4) begin
            k_q <= key_q[63:32];
            state_q <= SBlkMulK1;
          end else begin
            state_q <= STail;
          end
        end
        STail: begin
          case (len_q - pos_q)
            4'd3: h_q <= h_q ^ {8'd0, blk[23:0]};
            4'd2: h_q <= h_q ^ {16'd0, blk[15:0]};
            4'd1: h_q <= h_q ^ {24'd0, blk[7:0]};
            default: ;
          endcase
          state_q <= (len_q == pos_q) ? SFin1 : SFin2;
          pos_q <= (len_q == pos_q) ? pos_q : 4'd15;
        end
        SFin1: begin
          if (pos_q == 4'd15) begin
            h_q <= mul_y;
            pos_q <= '0;
          end else begin
            h_q <= h_q ^ (h_q >> 13);
            state_q <= SFin2;
          end
        end
        SFin2: begin
          if (pos_q == 4'd15) begin
            h_q <= mul_y;
            pos_q <= '0;
            state_q <= SFin1;
          end else begin
            h_q <= mul_y ^ (mul_y >> 15);
            if (!pass_q) begin
              a_q <= mul_y ^ (mul_y >> 15);
              pass_q <= 1'b1;
              state_q <= SHashInit;
            end else begin
              b_q <= mul_y ^ (mul_y >> 15);
              x_q <= a_q;
              i_q <= '0;
              all_q <= 1'b1;
              state_q <= SNext;
            end
          end
        end
        SNext: begin
          if (i_q == n_q) begin
            stat_q <= 1'b0;
            state_q <= SDone;
          end else begin
            rem_q <= '0;
            bit_q <= '0;
            state_q <= SMod;
          end
        end
        SMod: begin
          if (rem_sh >= {1'b0, m_q}) rem_q <= MW'(rem_sh - {1'b0, m_q});
          else rem_q <= rem_sh[MW-1:0];
          bit_q <= bit_q + 1'b1;
          if (bit_q == 6'd31) state_q <= SRead;
        end
        SRead: begin
          addr_q <= rem_q[AW-1:0];
          state_q <= SWait;
        end
        SWait: state_q <= STest;
        STest: begin
          x_q <= x_q + b_q;
          if (!rd_q) begin
            all_q <= 1'b0;
          end
          if (!rd_q && act_q == ActCheck) begin
            i_q <= n_q;
          end else begin
            i_q <= i_q + 1'b1;
          end
          state_q <= SNext;
        end
        SDone: begin
          if (out_free) begin
            present_q <= all_q;
            status_q <= stat_q;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> in_stall_o) else $error("request taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |=> (ovalid_q && $stable(present_q) && $stable(status_q)))
    else $error("result lost");
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SRead) |-> (rem_q < m_q)) else $error("probe out of range");

endmodule

// ----- bench/bfac_checker.sv -----
`timescale 1ns / 100ps

module bfac_checker
  import bfac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic [63:0] key_data_i,
  input  logic [3:0]  key_length_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        present_i,
  input  logic        status_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic present;
    logic status;
  } answer_t;

  logic        filter_bits [FilterBitsDef];
  logic        enabled_q;
  logic [5:0]  hash_count_q;
  logic [16:0] bit_count_q;
  answer_t     pending_answers [$];

  assign pending_o = pending_answers.size();

  function automatic logic [31:0] murmur2(logic [63:0] key, int unsigned len,
                                          logic [31:0] seed);
    logic [31:0] h;
    logic [31:0] k;
    int unsigned p;
    h = seed ^ len;
    p = 0;
    while (len - p >= 4) begin
      k = key[8*p +: 32];
      k = k * MixMul;
      k = k ^ (k >> 24);
      k = k * MixMul;
      h = h * MixMul;
      h = h ^ k;
      p += 4;
    end
    if (len - p == 3) h = h ^ ({24'd0, key[8*(p+2) +: 8]} << 16);
    if (len - p >= 2) h = h ^ ({24'd0, key[8*(p+1) +: 8]} << 8);
    if (len - p >= 1) begin
      h = h ^ {24'd0, key[8*p +: 8]};
      h = h * MixMul;
    end
    h = h ^ (h >> 13);
    h = h * MixMul;
    h = h ^ (h >> 15);
    return h;
  endfunction

  function automatic answer_t predict_membership(logic [1:0] act, logic [63:0] key,
                                                 logic [3:0] klen);
    answer_t     ans;
    logic [31:0] ha;
    logic [31:0] hb;
    logic [31:0] pos;
    int unsigned len;
    int unsigned probes;
    int unsigned modulus;
    ans = '0;
    if (!enabled_q) begin
      ans.status = 1'b1;
      return ans;
    end
    if (act == ActClear) begin
      foreach (filter_bits[j]) filter_bits[j] = 1'b0;
      return ans;
    end
    if (act != ActCheck && act != ActAdd) return ans;
    len = (klen > MaxKeyBytesDef) ? MaxKeyBytesDef : klen;
    ha = murmur2(key, len, HashSeed);
    hb = murmur2(key, len, ha);
    probes = (hash_count_q > MaxProbes) ? MaxProbes : hash_count_q;
    modulus = (bit_count_q == 0) ? 1 : bit_count_q;
    if (modulus > FilterBitsDef) modulus = FilterBitsDef;
    ans.present = 1'b1;
    for (int unsigned i = 0; i < probes; i++) begin
      pos = ha + hb * i;
      if (!filter_bits[pos % modulus]) begin
        ans.present = 1'b0;
        break;
      end
    end
    if (act == ActAdd) begin
      for (int unsigned i = 0; i < probes; i++) begin
        pos = ha + hb * i;
        filter_bits[pos % modulus] = 1'b1;
      end
    end
    return ans;
  endfunction

  initial begin
    foreach (filter_bits[j]) filter_bits[j] = 1'b0;
    enabled_q = 1'b0;
    hash_count_q = HashCountRst;
    bit_count_q = BitCountRst;
    errors_o = 0;
  end

  always @(posedge clk_i) begin
    answer_t exp_ans;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: result with none expected: present %0b status %0b",
                   $time, present_i, status_i);
          errors_o++;
        end else begin
          exp_ans = pending_answers.pop_front();
          if (present_i !== exp_ans.present) begin
            $display("%0t: present expected %0b actual %0b", $time,
                     exp_ans.present, present_i);
            errors_o++;
          end
          if (status_i !== exp_ans.status) begin
            $display("%0t: status expected %0b actual %0b", $time,
                     exp_ans.status, status_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        pending_answers.push_back(predict_membership(action_i, key_data_i, key_length_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegEnable:    enabled_q = cfg_data_i[0];
          RegHashCount: hash_count_q = cfg_data_i[5:0];
          RegBitCount:  bit_count_q = cfg_data_i[16:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import bfac_pkg::*;

  localparam logic [1:0] ActIgnored = 2'd3;
  localparam int QuietLimit = 250000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = ActCheck;
  logic [63:0] key_data_i = '0;
  logic [3:0]  key_length_i = 4'd1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        present_o;
  logic        status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = RegEnable;
  logic [31:0] cfg_data_i = '0;

  int          errors;
  int          pending;
  int          send_idle = 15;
  int          recv_idle = 62;
  bit          hold_off = 1'b0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;
  logic [63:0] key_pool [16];
  logic [3:0]  len_pool [16];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  bloom_filter_add_check_top u_top (.*);

  bfac_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i, .key_data_i,
    .key_length_i, .out_valid_i(out_valid_o), .out_stall_i, .present_i(present_o),
    .status_i(status_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .errors_o(errors), .pending_o(pending)
  );

  // receiver side, with a long hold when asked
  always @(posedge clk_i) begin
    if (hold_off && !hold_done) begin
      out_stall_i <= 1'b1;
      repeat (2500) @(posedge clk_i);
      hold_done = 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] act, logic [63:0] key, logic [3:0] len);
    in_valid_i <= 1'b1;
    action_i <= act;
    key_data_i <= key;
    key_length_i <= len;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_filter(logic en, logic [31:0] hashes, logic [31:0] bits);
    drain();
    write_reg(RegEnable, {31'd0, en});
    write_reg(RegHashCount, hashes);
    write_reg(RegBitCount, bits);
  endtask

  task automatic random_request;
    int          pick;
    logic [3:0]  slot;
    logic [1:0]  act;
    logic [63:0] key;
    logic [3:0]  len;
    pick = $urandom_range(0, 999);
    slot = 4'($urandom_range(0, 15));
    act = $urandom_range(0, 1) ? ActAdd : ActCheck;
    key = key_pool[slot];
    len = len_pool[slot];
    if (pick < 3) act = ActClear;
    else if (pick < 40) act = ActIgnored;
    else if (pick < 150) begin
      key = {$urandom, $urandom};
      len = 4'($urandom_range(0, 15));
    end
    send_request(act, key, len);
  endtask

  initial begin
    foreach (key_pool[j]) begin
      key_pool[j] = {$urandom, $urandom};
      len_pool[j] = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) :
                                                     $urandom_range(1, 8));
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled filter
    send_request(ActAdd, 64'hffff_ffff_ffff_ffff, 4'd15);
    send_request(ActCheck, 64'd0, 4'd0);
    send_request(ActClear, 64'd0, 4'd1);
    send_request(ActIgnored, 64'd0, 4'd1);

    // single bit, single probe
    set_filter(1'b1, 32'd1, 32'd1);
    send_request(ActCheck, 64'h1234, 4'd2);
    send_request(ActAdd, 64'hffff_ffff_ffff_ffff, 4'd8);
    send_request(ActCheck, 64'd0, 4'd1);
    send_request(ActCheck, 64'h0102_0304_0506_0708, 4'd5);

    // full size, most probes
    set_filter(1'b1, 32'd32, 32'd65536);
    send_request(ActAdd, 64'hffff_ffff_ffff_ffff, 4'd8);
    send_request(ActCheck, 64'hffff_ffff_ffff_ffff, 4'd8);
    send_request(ActCheck, 64'hffff_ffff_ffff_fffe, 4'd8);
    send_request(ActAdd, 64'hffff_ffff_ffff_ffff, 4'd8);
    send_request(ActAdd, 64'h0, 4'd0);
    send_request(ActCheck, 64'h0, 4'd0);
    send_request(ActClear, 64'h0, 4'd1);
    send_request(ActCheck, 64'hffff_ffff_ffff_ffff, 4'd8);

    // zero and oversize settings
    set_filter(1'b1, 32'd0, 32'd0);
    send_request(ActCheck, 64'h55, 4'd1);
    send_request(ActIgnored, 64'h55, 4'd1);
    set_filter(1'b1, 32'hffff_ffff, 32'h0001_ffff);
    send_request(ActAdd, 64'h8000_0000_0000_0001, 4'd12);
    send_request(ActCheck, 64'h8000_0000_0000_0001, 4'd8);
    send_request(ActCheck, 64'h8000_0000_0000_0001, 4'd7);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 15 : (mode == 1) ? 62 : 0;
      recv_idle = (mode == 0) ? 62 : (mode == 1) ? 15 : 0;
      for (int batch = 0; batch < 4; batch++) begin
        set_filter($urandom_range(0, 9) != 0, $urandom_range(1, 8),
                   $urandom_range(64, 2048));
        if (mode == 0 && batch == 1) hold_off = 1'b1;
        repeat (133) random_request();
      end
    end

    drain();
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bfac_pkg.sv
rtl/core/bloom_filter_add_check_top.sv
bench/bfac_checker.sv
bench/tb_top.sv
